/* rtl/core/ucfd_pkg.sv */
// Shared types and constants for the unstuffing frame deserialiser.
// Beat structs, escape codes, status codes and frame limits.
// No dependencies.
package ucfd_pkg;

  // Escape handling
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] FLAG_BYTE = 8'h7E;

  // Frame checks
  localparam logic [7:0] SUM_OK        = 8'hFF;
  localparam int         MIN_FRAME     = 7;
  localparam int         PAYLOAD_START = 6;
  localparam int         COUNT_BITS_DEF = 16;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ESC_ERR   = 2'd1;
  localparam logic [1:0] ST_TOO_SHORT = 2'd2;
  localparam logic [1:0] ST_SUM_ERR   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  control_byte;
    logic [7:0]  property_byte;
    logic [31:0] object_ref;
    logic [15:0] payload_count;
  } out_beat_t;

endpackage

/* rtl/core/ucfd_in_stage.sv */
// Input register stage: holds one accepted beat until the frame logic takes it.
// Depends on ucfd_pkg.
module ucfd_in_stage
  import ucfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  input  logic     advance,
  output logic     stage_valid,
  output in_beat_t stage_beat
);

  logic     valid_r, valid_nxt;
  in_beat_t beat_r;

  // Free when empty or when the held beat moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_data;
    end
  end

  assign stage_valid = valid_r;
  assign stage_beat  = beat_r;

endmodule

/* rtl/core/ucfd_frame.sv */
// Per-frame state: escape removal, byte sum, header capture and result build.
// Depends on ucfd_pkg.
module ucfd_frame
  import ucfd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_beat_t  beat,
  output logic      res_valid,
  output out_beat_t res
);

  localparam int WW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic                  esc_pend_r, esc_pend_nxt;
  logic                  esc_err_r, esc_err_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic [7:0]            ctrl_r, ctrl_nxt;
  logic [7:0]            prop_r, prop_nxt;
  logic [31:0]           obj_r, obj_nxt;

  logic                  have;
  logic [7:0]            val;
  logic                  last;
  logic                  emit;
  logic [WW-1:0]         diff;
  logic [1:0]            st;

  // Escape decode, state update and result build
  always_comb begin
    last         = beat.frame_end;
    have         = 1'b0;
    val          = beat.data_byte;
    esc_pend_nxt = esc_pend_r;
    esc_err_nxt  = esc_err_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    ctrl_nxt     = ctrl_r;
    prop_nxt     = prop_r;
    obj_nxt      = obj_r;
    emit         = 1'b0;

    if (!esc_err_r) begin
      if (esc_pend_r) begin
        esc_pend_nxt = 1'b0;
        if (beat.data_byte == ESC_FLAG) begin
          val  = FLAG_BYTE;
          have = 1'b1;
        end else if (beat.data_byte == ESC_ESC) begin
          val  = ESC_BYTE;
          have = 1'b1;
        end else begin
          esc_err_nxt = 1'b1;
        end
      end else if (beat.data_byte == ESC_BYTE) begin
        // escape in last position is an error too
        if (last) begin
          esc_err_nxt = 1'b1;
        end else begin
          esc_pend_nxt = 1'b1;
        end
      end else begin
        have = 1'b1;
      end
    end

    if (have) begin
      if (count_r == COUNT_BITS'(0)) begin
        ctrl_nxt = val;
      end
      if (count_r == COUNT_BITS'(1)) begin
        prop_nxt = val;
      end
      for (int k = 0; k < 4; k++) begin
        if (count_r == COUNT_BITS'(k + 2)) begin
          obj_nxt[8*k +: 8] = val;
        end
      end
      sum_nxt = sum_r + val;
      if (!(&count_r)) begin
        count_nxt = count_r + COUNT_BITS'(1);
      end
      emit = !last && (count_r >= COUNT_BITS'(PAYLOAD_START));
    end

    // Frame judgement on the updated state
    if (esc_err_nxt) begin
      st = ST_ESC_ERR;
    end else if (count_nxt < COUNT_BITS'(MIN_FRAME)) begin
      st = ST_TOO_SHORT;
    end else if (sum_nxt != SUM_OK) begin
      st = ST_SUM_ERR;
    end else begin
      st = ST_OK;
    end
    diff = WW'(count_nxt) - WW'(MIN_FRAME);

    res = '0;
    if (last) begin
      res.kind   = KIND_STATUS;
      res.status = st;
      if (st == ST_OK) begin
        res.control_byte  = ctrl_nxt;
        res.property_byte = prop_nxt;
        res.object_ref    = obj_nxt;
        res.payload_count = diff[15:0];
      end
    end else begin
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = val;
    end
    res_valid = go && (emit || last);
  end

  // State registers; a frame end returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r <= 1'b0;
      esc_err_r  <= 1'b0;
      count_r    <= '0;
      sum_r      <= '0;
      ctrl_r     <= '0;
      prop_r     <= '0;
      obj_r      <= '0;
    end else if (go) begin
      if (last) begin
        esc_pend_r <= 1'b0;
        esc_err_r  <= 1'b0;
        count_r    <= '0;
        sum_r      <= '0;
        ctrl_r     <= '0;
        prop_r     <= '0;
        obj_r      <= '0;
      end else begin
        esc_pend_r <= esc_pend_nxt;
        esc_err_r  <= esc_err_nxt;
        count_r    <= count_nxt;
        sum_r      <= sum_nxt;
        ctrl_r     <= ctrl_nxt;
        prop_r     <= prop_nxt;
        obj_r      <= obj_nxt;
      end
    end
  end

  // Checks
  a_err_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    esc_err_r |-> !esc_pend_r)
    else $error("escape error and pending escape both set");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && beat.frame_end |=> (count_r == '0) && !esc_err_r && (sum_r == '0))
    else $error("frame state not cleared after frame end");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    go && !beat.frame_end |=> count_r >= $past(count_r))
    else $error("byte count fell inside a frame");

  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.kind == KIND_STATUS) |-> beat.frame_end)
    else $error("status result without frame end");

  a_no_payload_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    esc_err_r && go |-> !(res_valid && (res.kind == KIND_PAYLOAD)))
    else $error("payload emitted after escape error");

endmodule

/* rtl/core/unstuff_checksum_frame_deserializer.sv */
// Top level of the unstuffing frame deserialiser: input stage, frame logic,
// result register. Depends on ucfd_pkg, ucfd_in_stage and ucfd_frame.
//
// Takes one stuffed byte per beat and can accept a beat every clock cycle. A
// beat passes through an input register, then escape removal, sum and header
// capture, and its result (if any) is loaded into the output register.
// Each beat gives at most one result: a payload byte from de-escaped index 6
// on (never on the frame's last beat), or one status beat at frame end.
// Payload goes out before the frame is judged, so discard it when the status
// is not ok. in_ready only drops while the output register holds a result that
// has not been taken.
module unstuff_checksum_frame_deserializer
  import ucfd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      stage_valid;
  in_beat_t  stage_beat;
  logic      go;
  logic      res_valid;
  out_beat_t res;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;

  // Input register
  ucfd_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .advance     (go),
    .stage_valid (stage_valid),
    .stage_beat  (stage_beat)
  );

  // Process a held beat whenever the result register is free or being drained
  assign go = stage_valid && (!out_valid_r || out_ready);

  ucfd_frame #(
    .COUNT_BITS (COUNT_BITS)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .beat      (stage_beat),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/tb_unstuff_checksum_frame_deserializer.sv */
// Self-checking testbench for unstuff_checksum_frame_deserializer.
// Sends stuffed frames over the input channel and checks each result beat
// against an internal frame predictor. Depends on ucfd_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_unstuff_checksum_frame_deserializer;
  import ucfd_pkg::*;

  localparam int CNT_W        = COUNT_BITS_DEF;
  localparam int RANDOM_BEATS = 1500;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 50000;

  typedef logic [7:0] byte_q_t[$];

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Predicted frame state
  logic             pend_esc;
  logic             bad_esc;
  logic [CNT_W-1:0] deframed_cnt;
  logic [7:0]       byte_sum;
  logic [7:0]       hdr_ctrl;
  logic [7:0]       hdr_prop;
  logic [31:0]      hdr_obj;

  out_beat_t expected_results[$];
  out_beat_t oldest;

  unstuff_checksum_frame_deserializer #(
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_unstuff_checksum_frame_deserializer: errors");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void clear_frame();
    pend_esc = 1'b0;
    bad_esc = 1'b0;
    deframed_cnt = '0;
    byte_sum = '0;
    hdr_ctrl = '0;
    hdr_prop = '0;
    hdr_obj = '0;
  endfunction

  // Frame predictor: one accepted beat in, at most one result out
  function automatic void predict_beat(input logic [7:0] b, input logic last,
                                       output logic produced, output out_beat_t r);
    logic       got;
    logic [7:0] v;
    int         idx;
    got = 1'b0;
    v = '0;
    produced = 1'b0;
    r = '0;
    if (!bad_esc) begin
      if (pend_esc) begin
        pend_esc = 1'b0;
        if (b == ESC_FLAG) begin
          v = FLAG_BYTE;
          got = 1'b1;
        end else if (b == ESC_ESC) begin
          v = ESC_BYTE;
          got = 1'b1;
        end else begin
          bad_esc = 1'b1;
        end
      end else if (b == ESC_BYTE) begin
        if (last) bad_esc = 1'b1;
        else pend_esc = 1'b1;
      end else begin
        v = b;
        got = 1'b1;
      end
    end
    if (got) begin
      idx = int'(deframed_cnt);
      if (idx == 0) hdr_ctrl = v;
      else if (idx == 1) hdr_prop = v;
      else if (idx < PAYLOAD_START) hdr_obj[8*(idx-2) +: 8] = v;
      byte_sum = byte_sum + v;
      if (deframed_cnt != '1) deframed_cnt = deframed_cnt + CNT_W'(1);
      // no payload on the frame's last beat, so the checksum byte never shows
      if (!last && idx >= PAYLOAD_START) begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = v;
        produced = 1'b1;
      end
    end
    if (last) begin
      r = '0;
      r.kind = KIND_STATUS;
      if (bad_esc) r.status = ST_ESC_ERR;
      else if (deframed_cnt < MIN_FRAME) r.status = ST_TOO_SHORT;
      else if (byte_sum != SUM_OK) r.status = ST_SUM_ERR;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        r.control_byte = hdr_ctrl;
        r.property_byte = hdr_prop;
        r.object_ref = hdr_obj;
        r.payload_count = 16'(deframed_cnt - MIN_FRAME);
      end
      produced = 1'b1;
      clear_frame();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %0h", $time, out_data);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("kind", 32'(oldest.kind), 32'(out_data.kind));
        check_field("payload_byte", 32'(oldest.payload_byte),
                    32'(out_data.payload_byte));
        check_field("status", 32'(oldest.status), 32'(out_data.status));
        check_field("control_byte", 32'(oldest.control_byte),
                    32'(out_data.control_byte));
        check_field("property_byte", 32'(oldest.property_byte),
                    32'(out_data.property_byte));
        check_field("object_ref", oldest.object_ref, out_data.object_ref);
        check_field("payload_count", 32'(oldest.payload_count),
                    32'(out_data.payload_count));
      end
    end
  end

  // Sends one beat; called and returns at a rising edge
  task automatic send_beat(input logic [7:0] b, input logic last);
    logic      produced;
    out_beat_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, frame_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b, last, produced, r);
    if (produced) expected_results.push_back(r);
  endtask

  task automatic send_frame(input byte_q_t beats);
    foreach (beats[i]) send_beat(beats[i], i == beats.size() - 1);
  endtask

  // Biased towards the escape and flag codes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return ESC_BYTE;
      1: return FLAG_BYTE;
      2: return $urandom_range(0, 1) ? ESC_ESC : ESC_FLAG;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(pick_byte());
    return q;
  endfunction

  function automatic byte_q_t with_checksum(input byte_q_t body);
    logic [7:0] s;
    byte_q_t    f;
    s = '0;
    f = body;
    foreach (body[i]) s = s + body[i];
    f.push_back(SUM_OK - s);
    return f;
  endfunction

  // Escape the flag and escape codes for the line
  function automatic byte_q_t stuff_bytes(input byte_q_t plain);
    byte_q_t line_bytes;
    foreach (plain[i]) begin
      if (plain[i] == FLAG_BYTE) begin
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(ESC_FLAG);
      end else if (plain[i] == ESC_BYTE) begin
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(ESC_ESC);
      end else begin
        line_bytes.push_back(plain[i]);
      end
    end
    return line_bytes;
  endfunction

  task automatic test_directed_frames();
    byte_q_t plain;
    byte_q_t beats;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    // good frame, escaped header bytes, header extremes, one payload byte
    plain = '{FLAG_BYTE, ESC_BYTE, 8'h00, 8'hFF, 8'h80, 8'h01, FLAG_BYTE};
    send_frame(stuff_bytes(with_checksum(plain)));
    // sum fine but too short
    plain = '{8'h01};
    send_frame(stuff_bytes(with_checksum(plain)));
    // single byte, short and bad sum: short wins
    beats = '{8'h00};
    send_frame(beats);
    // bad escape, trailing byte ignored
    beats = '{ESC_BYTE, 8'h41, 8'h00};
    send_frame(beats);
    // escape as the last byte
    beats = '{ESC_BYTE};
    send_frame(beats);
    // long enough, bad sum
    beats = '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70};
    send_frame(beats);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int         sent;
    int         shape;
    int         len;
    int         pos;
    logic [7:0] bad;
    byte_q_t    plain;
    byte_q_t    beats;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < RANDOM_BEATS / 4) begin
      shape = $urandom_range(0, 99);
      len = (shape >= 78 && shape < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      plain = with_checksum(random_body(len - 1));
      // broken checksum
      if (shape >= 70 && shape < 78) plain[len-1] ^= 8'($urandom_range(1, 255));
      beats = stuff_bytes(plain);
      if (shape >= 85 && shape < 92) begin
        // illegal escape somewhere in the frame
        pos = $urandom_range(0, beats.size() - 1);
        do bad = 8'($urandom_range(0, 255)); while (bad == ESC_FLAG || bad == ESC_ESC);
        beats.insert(pos, bad);
        beats.insert(pos, ESC_BYTE);
      end else if (shape >= 92 && shape < 96) begin
        beats.push_back(ESC_BYTE);
      end else if (shape >= 96) begin
        // line noise
        beats.delete();
        repeat ($urandom_range(1, 12)) beats.push_back(pick_byte());
      end
      send_frame(beats);
      sent += beats.size();
    end
  endtask

  task automatic test_random_frames();
    run_random_phase(0, 0);
    run_random_phase(56, 0);
    run_random_phase(0, 56);
    run_random_phase(38, 38);
  endtask

  initial begin
    clear_frame();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_random_frames();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_unstuff_checksum_frame_deserializer: clean");
    end else begin
      $display("tb_unstuff_checksum_frame_deserializer: errors");
    end
    $finish;
  end

endmodule
